FILE: sv/binary_opening_3x3_packed_macros.svh
// Assertion macros shared by the binary opening block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BINARY_OPENING_3X3_PACKED_MACROS_SVH
`define BINARY_OPENING_3X3_PACKED_MACROS_SVH

// Flag a condition that must never be seen outside reset.
`define BOP3_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Flag a consequence that must hold in the same cycle as its cause.
`define BOP3_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/bop3_pkg.sv
// Shared types, constants and word-level morphology functions for the
// binary opening block. Depends on nothing.
`timescale 1ns / 1ps

package bop3_pkg;

   localparam int WORD_BITS           = 64;
   localparam int MAX_WIDTH_WORDS_DEF = 32;
   localparam int MAX_ROWS_DEF        = 4096;
   localparam int MAX_RESULTS         = 3;
   localparam int OQ_DEPTH            = 4;
   localparam int OQ_AW               = 2;
   localparam int CSR_AW              = 4;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [3:0][WORD_BITS-1:0] hist_type;
   typedef logic [4:0][WORD_BITS-1:0] col_type;
   typedef logic [4:0][4:0][WORD_BITS-1:0] win_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_BORDER = 2'd2
   } csr_index_type;

   typedef struct packed {
      word_type opened;
      logic     last_of_frame;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [MAX_RESULTS-1:0] items;
      logic [1:0]                     count;
   } res_set_type;

   // Position flags of an item, worked out when it is accepted.
   typedef struct packed {
      logic       first_col;
      logic       last_col;
      logic       c_ge1;
      logic       c_ge2;
      logic       rc_ok;
      logic       last_row;
      logic [3:0] pre_top;
   } s1_ctrl_type;

   function automatic word_type nb_left(word_type cur, word_type prev);
      return {prev[0], cur[WORD_BITS-1:1]};
   endfunction

   function automatic word_type nb_right(word_type cur, word_type next);
      return {cur[WORD_BITS-2:0], next[WORD_BITS-1]};
   endfunction

   function automatic win_type shift_win(win_type w, col_type c);
      win_type r;
      for (int rr = 0; rr < 5; rr++) begin
         for (int cc = 0; cc < 4; cc++) begin
            r[rr][cc] = w[rr][cc+1];
         end
         r[rr][4] = c[rr];
      end
      return r;
   endfunction

   // Erode the 3x3 block of centers, then dilate around the middle word.
   function automatic word_type opening_of(win_type w);
      word_type ero [3][3];
      word_type acc;
      word_type m;
      word_type res;
      res = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            acc = '1;
            for (int d = 0; d < 3; d++) begin
               m = w[a+d][b+1];
               acc &= nb_left(m, w[a+d][b]) & m & nb_right(m, w[a+d][b+2]);
            end
            ero[a][b] = acc;
         end
      end
      for (int a = 0; a < 3; a++) begin
         res |= nb_left(ero[a][1], ero[a][0]) | ero[a][1] | nb_right(ero[a][1], ero[a][2]);
      end
      return res;
   endfunction

endpackage

FILE: sv/binary_opening_3x3_packed.sv
// Binary 3x3 morphological opening (erosion then dilation, fused) over a
// packed image, 64 pixels per word, leftmost pixel in bit 63, raster order.
// Depends on bop3_pkg, bop3_line_buf, bop3_window, bop3_out_fifo and the
// macros header. The block takes one item per clock: an accepted item is
// registered together with its column from the line buffer, and the window
// logic then shifts it in and pushes zero to three result items into a
// four-entry output queue, from which results are presented. The input
// stalls only when that queue has no room for the item's results, which
// for images at least three words wide depends on the consumer alone: the
// three results released by the last word of a row are absorbed while the
// first two words of the next row release none. After the image rows the
// host sends 2*width_words flush items (border rows); the last result of the
// frame carries last_of_frame, and the position counters then wrap for the
// next frame. Registers: width_words at 0x0, height_rows at 0x4 and
// border_fill at 0x8; any write restarts the frame and is to be done only
// while the block is idle.
`timescale 1ns / 1ps
`include "binary_opening_3x3_packed_macros.svh"

module binary_opening_3x3_packed import bop3_pkg::*; #(
   parameter int MAX_WIDTH_WORDS = MAX_WIDTH_WORDS_DEF,
   parameter int MAX_ROWS        = MAX_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [63:0]          req_pixels,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_opened,
   output logic                 rsp_last_of_frame,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   // Column index into the line buffer, column counter (holds 2 for the
   // compares) and row counter (runs through the two flush rows).
   localparam int AW = (MAX_WIDTH_WORDS > 1) ? $clog2(MAX_WIDTH_WORDS) : 1;
   localparam int CW = (AW < 2) ? 2 : AW;
   localparam int RW = ($clog2(MAX_ROWS + 2) < 3) ? 3 : $clog2(MAX_ROWS + 2);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [5:0]  width_ff;
   logic [12:0] height_ff;
   logic        border_ff;
   logic        csr_wr;
   logic [CW-1:0] w_last;
   logic [RW-1:0] h_last;
   word_type      border_word;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 6'd32;
         height_ff <= 13'd480;
         border_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_WIDTH:  width_ff  <= csr_pwdata[5:0];
            REG_HEIGHT: height_ff <= csr_pwdata[12:0];
            REG_BORDER: border_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = {26'd0, width_ff};
         REG_HEIGHT: csr_prdata = {19'd0, height_ff};
         REG_BORDER: csr_prdata = {31'd0, border_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Clamp the geometry: zero acts as one, oversize acts as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         w_last = '0;
      end else if (int'(width_ff) > MAX_WIDTH_WORDS) begin
         w_last = CW'(MAX_WIDTH_WORDS - 1);
      end else begin
         w_last = CW'(width_ff - 6'd1);
      end
      if (height_ff == '0) begin
         h_last = '0;
      end else if (int'(height_ff) > MAX_ROWS) begin
         h_last = RW'(MAX_ROWS - 1);
      end else begin
         h_last = RW'(height_ff - 13'd1);
      end
   end

   assign border_word = {WORD_BITS{border_ff}};

   // ---------------------------------------------------------------
   // Input position and the registered item stage
   // ---------------------------------------------------------------
   logic          in_acc;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] col_ff;
   logic          last_col;
   logic          frame_end;
   s1_ctrl_type   ctrl_in;
   word_type      cur_in;

   logic          s1_valid_ff;
   s1_ctrl_type   s1_ctrl_ff;
   word_type      s1_cur_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s1_fire;
   logic          oq_room;

   res_set_type     res;
   hist_type        rd_hist;
   hist_type        hist_m;
   hist_type        wr_hist;
   rsp_item_type    head;
   logic [OQ_AW:0]  oq_count;
   logic            pop;
   logic            frame_done;
   logic            pos_home;

   assign in_acc    = req_valid && req_ready;
   assign req_ready = !s1_valid_ff || s1_fire;

   assign last_col  = (col_ff == w_last);
   assign frame_end = (row_ff == h_last + RW'(2));

   always_comb begin
      ctrl_in.first_col  = (col_ff == '0);
      ctrl_in.last_col   = last_col;
      ctrl_in.c_ge1      = (col_ff >= CW'(1));
      ctrl_in.c_ge2      = (col_ff >= CW'(2));
      ctrl_in.rc_ok      = (row_ff >= RW'(2));
      ctrl_in.last_row   = frame_end;
      // Rows above the image read as border, whatever the buffer holds.
      ctrl_in.pre_top[0] = (row_ff < RW'(4));
      ctrl_in.pre_top[1] = (row_ff < RW'(3));
      ctrl_in.pre_top[2] = (row_ff < RW'(2));
      ctrl_in.pre_top[3] = (row_ff == '0);
      // Flush rows and border items stand for a border word.
      cur_in = (req_mode || (row_ff > h_last)) ? border_word : req_pixels;
   end

   // Advance the raster position on every accepted item; wrap at frame end; clear on any write.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (csr_wr) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (in_acc) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= frame_end ? '0 : row_ff + RW'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Hold the item payload until the window stage takes it.
   always_ff @(posedge clock) begin
      if (in_acc) begin
         s1_ctrl_ff <= ctrl_in;
         s1_cur_ff  <= cur_in;
         s1_addr_ff <= col_ff[AW-1:0];
      end
   end

   // Only release the item when the queue can take all its results.
   assign oq_room = ({1'b0, oq_count} + (OQ_AW+2)'(res.count)) <= (OQ_AW+2)'(OQ_DEPTH);
   assign s1_fire = s1_valid_ff && oq_room;

   // ---------------------------------------------------------------
   // Line buffer: four past rows per column, read at accept, written back
   // with the current word appended when the item leaves the stage.
   // ---------------------------------------------------------------
   always_comb begin
      for (int d = 0; d < 4; d++) begin
         hist_m[d] = s1_ctrl_ff.pre_top[d] ? border_word : rd_hist[d];
      end
      wr_hist[0] = rd_hist[1];
      wr_hist[1] = rd_hist[2];
      wr_hist[2] = rd_hist[3];
      wr_hist[3] = s1_cur_ff;
   end

   bop3_line_buf #(
      .DEPTH (MAX_WIDTH_WORDS)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (in_acc),
      .rd_addr (col_ff[AW-1:0]),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_hist),
      .rd_data (rd_hist)
   );

   bop3_window u_window (
      .clock  (clock),
      .fire   (s1_fire),
      .ctrl   (s1_ctrl_ff),
      .hist   (hist_m),
      .cur    (s1_cur_ff),
      .border (border_word),
      .res    (res)
   );

   // ---------------------------------------------------------------
   // Result queue and output channel
   // ---------------------------------------------------------------
   assign rsp_valid = (oq_count != '0);
   assign pop       = rsp_valid && rsp_ready;

   bop3_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_fire),
      .push_set (res),
      .pop      (pop),
      .head     (head),
      .count    (oq_count)
   );

   assign rsp_opened        = head.opened;
   assign rsp_last_of_frame = head.last_of_frame;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // The last item of a frame leaves the stage with the position at home.
   assign frame_done = s1_fire && s1_ctrl_ff.last_row && s1_ctrl_ff.last_col;
   assign pos_home   = (row_ff == '0) && (col_ff == '0);

   `BOP3_ASSERT_NEVER(a_oq_overflow, clock, reset, oq_count > (OQ_AW+1)'(OQ_DEPTH), "queue overflow")
   `BOP3_ASSERT_NEVER(a_col_in_range, clock, reset, col_ff > w_last, "column beyond image width")
   `BOP3_ASSERT_IMPLY(a_frame_wrap, clock, reset, frame_done, pos_home, "no wrap at frame end")

endmodule

FILE: sv/bop3_line_buf.sv
// Column-organized line buffer: one entry per word column holding the
// last four rows. Depends on bop3_pkg.
`timescale 1ns / 1ps

module bop3_line_buf import bop3_pkg::*; #(
   parameter int DEPTH = MAX_WIDTH_WORDS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  hist_type      wr_data,
   output hist_type      rd_data
);

   hist_type mem [DEPTH];
   hist_type rd_data_ff;

   // Forward a same-cycle write so a one-word-wide image reads fresh data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bop3_window.sv
// 5x5-word window registers and the fused erode/dilate logic producing
// up to three result items per input item. Depends on bop3_pkg.
`timescale 1ns / 1ps

module bop3_window import bop3_pkg::*; (
   input  logic        clock,
   input  logic        fire,
   input  s1_ctrl_type ctrl,
   input  hist_type    hist,
   input  word_type    cur,
   input  word_type    border,
   output res_set_type res
);

   win_type      win_ff;
   win_type      win_in;
   win_type      base;
   win_type      w2;
   win_type      w3;
   col_type      new_col;
   col_type      border_col;
   rsp_item_type r0;
   rsp_item_type r1;
   rsp_item_type r2;
   logic         v0;
   logic         v1;
   logic         v2;

   always_comb begin
      for (int r = 0; r < 5; r++) begin
         border_col[r] = border;
         for (int c = 0; c < 5; c++) begin
            base[r][c] = ctrl.first_col ? border : win_ff[r][c];
         end
      end
      for (int d = 0; d < 4; d++) begin
         new_col[d] = hist[d];
      end
      new_col[4] = cur;

      // Shift in the new column, then two border columns at the row end.
      win_in = shift_win(base, new_col);
      w2     = shift_win(win_in, border_col);
      w3     = shift_win(w2, border_col);

      r0.opened        = opening_of(win_in);
      r0.last_of_frame = 1'b0;
      r1.opened        = opening_of(w2);
      r1.last_of_frame = 1'b0;
      r2.opened        = opening_of(w3);
      r2.last_of_frame = ctrl.last_row;

      v0 = ctrl.rc_ok && ctrl.c_ge2;
      v1 = ctrl.rc_ok && ctrl.last_col && ctrl.c_ge1;
      v2 = ctrl.rc_ok && ctrl.last_col;

      // Pack the valid results to the front, in column order.
      res.items = {r2, r2, r2};
      res.count = 2'd0;
      if (v0) begin
         res.items[0] = r0;
         res.items[1] = r1;
         res.items[2] = r2;
         res.count    = ctrl.last_col ? 2'd3 : 2'd1;
      end else if (v1) begin
         res.items[0] = r1;
         res.items[1] = r2;
         res.count    = 2'd2;
      end else if (v2) begin
         res.items[0] = r2;
         res.count    = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         win_ff <= win_in;
      end
   end

endmodule

FILE: sv/bop3_out_fifo.sv
// Small result queue: takes up to three items at once, hands out one per
// cycle while pop is high. Depends on bop3_pkg.
`timescale 1ns / 1ps

module bop3_out_fifo import bop3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  res_set_type      push_set,
   input  logic             pop,
   output rsp_item_type     head,
   output logic [OQ_AW:0]   count
);

   rsp_item_type     q_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] wp_ff;
   logic [OQ_AW-1:0] rp_ff;
   logic [OQ_AW:0]   count_ff;
   logic [OQ_AW:0]   count_in;
   logic [OQ_AW:0]   n_push;

   assign n_push   = push ? (OQ_AW+1)'(push_set.count) : '0;
   assign count_in = count_ff + n_push - (OQ_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if (2'(j) < push_set.count) begin
               q_ff[wp_ff + OQ_AW'(j)] <= push_set.items[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + OQ_AW'(push_set.count);
         end
         if (pop) begin
            rp_ff <= rp_ff + OQ_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   assign head  = q_ff[rp_ff];
   assign count = count_ff;

endmodule

FILE: tb/sv/binary_opening_3x3_packed_tb.sv
// Self-checking testbench for binary_opening_3x3_packed: drives packed image
// frames and flush items, predicts every opened word and checks it in order.
// Depends on bop3_pkg and the binary_opening_3x3_packed RTL.
`timescale 1ns / 1ps

module binary_opening_3x3_packed_tb import bop3_pkg::*;;

   localparam int          CYCLE_LIMIT     = 200_000;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          IDLE_PCT        = 18;
   localparam int          RANDOM_ITEMS    = 20;
   localparam int          CLAMP_ITEMS     = 8;
   localparam logic [1:0]  UNMAPPED_INDEX  = 2'd3;
   localparam word_type    ALL_ONES        = {WORD_BITS{1'b1}};

   // One opened word as the block should present it.
   typedef struct {
      word_type opened;
      logic     last_of_frame;
   } opened_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = 1'b0;
   logic [63:0]       req_pixels = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [63:0]       rsp_opened;
   logic              rsp_last_of_frame;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // Shadow of the register file, as written.
   logic [5:0]        width_reg = 6'd32;
   logic [12:0]       height_reg = 13'd480;
   logic              border_reg = 1'b0;

   // Shadow of the block's stored rows, window and raster position.
   word_type          row_hist [4][MAX_WIDTH_WORDS_DEF];
   word_type          win_grid [5][5];
   int                pos_row = 0;
   int                pos_col = 0;

   opened_word_type   expected_words [$];
   int                error_count = 0;
   int                accepted_items = 0;
   int                cycle_count = 0;
   bit                calm = 1'b0;   // set to suppress all idling on both sides

   binary_opening_3x3_packed DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_pixels        (req_pixels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_opened        (rsp_opened),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Opening predictor
   // ------------------------------------------------------------------

   // Clamp the width register to 1..MAX: zero acts as one word.
   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_WORDS_DEF) return MAX_WIDTH_WORDS_DEF;
      return int'(width_reg);
   endfunction

   function automatic bit height_rows_zero();
      return height_reg == 0;
   endfunction

   function automatic int active_height();
      if (height_rows_zero()) return 1;
      if (height_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
      return int'(height_reg);
   endfunction

   // AND of each middle pixel with its left and right neighbours. Bit 63 is
   // leftmost, so the left neighbour sits one bit higher in {l, m, r}.
   function automatic word_type squeeze3(word_type l, word_type m, word_type r);
      logic [3*WORD_BITS-1:0] strip;
      strip = {l, m, r};
      return strip[2*WORD_BITS:WORD_BITS+1] & strip[2*WORD_BITS-1:WORD_BITS]
             & strip[2*WORD_BITS-2:WORD_BITS-1];
   endfunction

   function automatic word_type spread3(word_type l, word_type m, word_type r);
      logic [3*WORD_BITS-1:0] strip;
      strip = {l, m, r};
      return strip[2*WORD_BITS:WORD_BITS+1] | strip[2*WORD_BITS-1:WORD_BITS]
             | strip[2*WORD_BITS-2:WORD_BITS-1];
   endfunction

   // Erode the 3x3 words around the window center, then dilate the middle one.
   function automatic word_type opened_center();
      word_type core [3];
      word_type acc;
      word_type res;
      res = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            acc = ALL_ONES;
            for (int d = 0; d < 3; d++) begin
               acc &= squeeze3(win_grid[a+d][b], win_grid[a+d][b+1], win_grid[a+d][b+2]);
            end
            core[b] = acc;
         end
         res |= spread3(core[0], core[1], core[2]);
      end
      return res;
   endfunction

   function automatic void push_column(word_type column [5]);
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 4; c++) begin
            win_grid[r][c] = win_grid[r][c+1];
         end
         win_grid[r][4] = column[r];
      end
   endfunction

   function automatic void restart_prediction();
      pos_row = 0;
      pos_col = 0;
   endfunction

   // Advance the shadow by one accepted item and queue the words it releases.
   function automatic void predict_opening(logic mode, word_type pixels);
      int              w;
      int              h;
      int              rr;
      int              rc;
      int              cc;
      int              extra;
      word_type        pad_word;
      word_type        cur;
      word_type        column [5];
      opened_word_type due;
      w = active_width();
      h = active_height();
      pad_word = {WORD_BITS{border_reg}};
      // Border ticks and anything in the two flush rows stand for padding.
      cur = (mode || pos_row >= h) ? pad_word : pixels;
      for (int d = 0; d < 4; d++) begin
         rr = pos_row - 4 + d;
         column[d] = (rr < 0) ? pad_word : row_hist[rr & 3][pos_col];
      end
      column[4] = cur;
      row_hist[pos_row & 3][pos_col] = cur;
      if (pos_col == 0) begin
         for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
               win_grid[r][c] = pad_word;
            end
         end
      end
      // The last word of a row also shifts in two padding columns.
      extra = (pos_col == w - 1) ? 2 : 0;
      rc = pos_row - 2;
      for (int k = 0; k <= extra; k++) begin
         push_column(column);
         for (int d = 0; d < 5; d++) begin
            column[d] = pad_word;
         end
         cc = pos_col - 2 + k;
         if (rc >= 0 && cc >= 0) begin
            due.opened = opened_center();
            due.last_of_frame = (rc == h - 1) && (cc == w - 1);
            expected_words.push_back(due);
         end
      end
      if (pos_col + 1 >= w) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= h + 2) pos_row = 0;
      end else begin
         pos_col++;
      end
   endfunction

   function automatic logic [31:0] reg_view(logic [1:0] idx);
      case (idx)
         REG_WIDTH:  return {26'd0, width_reg};
         REG_HEIGHT: return {19'd0, height_reg};
         REG_BORDER: return {31'd0, border_reg};
         default:    return '0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   // Compare each accepted result with the oldest prediction, then pick the
   // ready for the next cycle.
   always @(posedge clock) begin : check_results
      opened_word_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result: opened %h last_of_frame %b",
                   rsp_opened, rsp_last_of_frame);
            error_count++;
         end else begin
            due = expected_words.pop_front();
            if (rsp_opened !== due.opened) begin
               $error("opened: expected %h, got %h", due.opened, rsp_opened);
               error_count++;
            end
            if (rsp_last_of_frame !== due.last_of_frame) begin
               $error("last_of_frame: expected %b, got %b",
                      due.last_of_frame, rsp_last_of_frame);
               error_count++;
            end
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   function automatic word_type random_pixels();
      word_type a;
      word_type b;
      word_type c;
      a = {$urandom(), $urandom()};
      b = {$urandom(), $urandom()};
      c = {$urandom(), $urandom()};
      case ($urandom_range(5))
         0:       return a;
         1:       return a | b | c;              // dense: erosion survives often
         2:       return ALL_ONES;
         3:       return '0;
         4:       return a | b | c | {$urandom(), $urandom()};
         default: return ALL_ONES ^ (word_type'(1) << $urandom_range(63));
      endcase
   endfunction

   // Present one item and hold it until accepted. Valid is lowered only
   // for an idle gap, so it never falls and rises in the same step.
   task automatic send_item(logic mode, word_type pixels);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_pixels <= pixels;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_opening(mode, pixels);
      accepted_items++;
   endtask

   // Hold the input until every predicted word has come back.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Drain, then let items that release nothing leave the pipeline too.
   task automatic settle_block();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Image rows, then the two flush rows. noise_pct sets how often a border
   // tick lands inside the image and an image word lands in the flush.
   task automatic send_frame(int noise_pct, int pause_at);
      int w;
      int h;
      int idx;
      w = active_width();
      h = active_height();
      idx = 0;
      for (int r = 0; r < h + 2; r++) begin
         for (int c = 0; c < w; c++) begin
            if (idx == pause_at) wait_results_drained();
            if (r < h) send_item($urandom_range(99) < noise_pct, random_pixels());
            else send_item($urandom_range(99) >= noise_pct, random_pixels());
            idx++;
         end
      end
   endtask

   // APB write: setup cycle, then access until pready. Any write restarts
   // the frame, mapped or not.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_WIDTH:  width_reg = value[5:0];
         REG_HEIGHT: height_reg = value[12:0];
         REG_BORDER: border_reg = value[0];
         default:    ;
      endcase
      restart_prediction();
      @(posedge clock);
   endtask

   // Write a register, then read it back and compare with the shadow.
   task automatic write_and_verify(csr_index_type idx, logic [31:0] value);
      csr_write(idx, value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== reg_view(idx)) begin
         $error("prdata of %s: expected %h, got %h", idx.name(), reg_view(idx), csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(logic [31:0] w, logic [31:0] h, logic [31:0] b);
      settle_block();
      write_and_verify(REG_WIDTH, w);
      write_and_verify(REG_HEIGHT, h);
      write_and_verify(REG_BORDER, b);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Small frame with solid, striped and corner-bit words, a border tick
   // inside the image and image words inside the flush.
   task automatic test_directed_patterns();
      set_geometry(2, 3, 0);
      send_item(1'b0, ALL_ONES);
      send_item(1'b0, ALL_ONES);
      send_item(1'b0, ALL_ONES);
      send_item(1'b1, ALL_ONES);                      // border tick in image
      send_item(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(1'b0, 64'h8000_0000_0000_0001);
      send_item(1'b1, '0);
      send_item(1'b0, ALL_ONES);                      // image word in flush
      send_item(1'b1, ALL_ONES);
      send_item(1'b0, 64'h5555_5555_5555_5555);
   endtask

   // Padding of ones: a zero word erodes its neighbours, ones at the edge survive.
   task automatic test_border_fill();
      set_geometry(1, 2, 1);
      send_item(1'b0, '0);
      send_item(1'b0, 64'h7FFF_FFFF_FFFF_FFFE);
      send_item(1'b1, '0);
      send_item(1'b0, '0);
   endtask

   // Out-of-range sizes: width 0 acts as 1 and height 8191 as the row
   // limit, so a few rows see no flush and no frame end before the next
   // write restarts the frame; then width 63 acts as the word limit and
   // height 0 as 1.
   task automatic test_clamped_sizes();
      set_geometry(0, 13'h1FFF, 0);
      for (int i = 0; i < CLAMP_ITEMS; i++) send_item(1'b0, random_pixels());
      set_geometry(6'h3F, 0, 1);
      send_frame(8, -1);
   endtask

   // Two frames without a write: counters wrap after the last word.
   task automatic test_frame_wrap();
      set_geometry(3, 2, 0);
      calm = 1'b1;
      send_frame(0, -1);
      send_frame(20, -1);
      calm = 1'b0;
   endtask

   // Stop mid-frame, write an unmapped index, and start a fresh frame.
   task automatic test_restart_on_write();
      set_geometry(2, 6, 0);
      for (int i = 0; i < 9; i++) send_item($urandom_range(9) == 0, random_pixels());
      settle_block();
      csr_write(UNMAPPED_INDEX, $urandom());
      send_frame(10, -1);
   endtask

   // Random small geometries with junk in the unused register bits.
   task automatic test_random_frames();
      int start;
      int round;
      int w;
      int h;
      int pause_at;
      start = accepted_items;
      round = 0;
      while (accepted_items - start < RANDOM_ITEMS) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         h = $urandom_range(1, 6);
         set_geometry(($urandom() & ~32'h3F) | w, ($urandom() & ~32'h1FFF) | h,
                      ($urandom() & ~32'h1) | $urandom_range(1));
         calm = ($urandom_range(3) == 0);
         for (int f = 0; f < $urandom_range(1, 2); f++) begin
            pause_at = (round == 0 || $urandom_range(2) == 0)
                       ? $urandom_range(w * (h + 2) - 1) : -1;
            send_frame($urandom_range(15), pause_at);
            round++;
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_patterns();
      test_border_fill();
      test_clamped_sizes();
      test_frame_wrap();
      test_restart_on_write();
      test_random_frames();
      settle_block();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
